// File: rtl/core/bfir_pkg.sv
`default_nettype none

package bfir_pkg;

  localparam int TAPS_DEF    = 64;
  localparam int COEF_BITS   = 16;
  localparam int SAMPLE_W    = 12;
  localparam int X_W         = SAMPLE_W + 1;
  localparam int TAP_FIELD_W = 6;
  localparam int TAP_IDX_W   = 8;

  localparam int FS_SHIFT    = SAMPLE_W;
  localparam int HS_SHIFT    = SAMPLE_W - 1;
  localparam int FULL_SCALE  = (1 << FS_SHIFT) - 1;
  localparam int HALF_SCALE  = (1 << HS_SHIFT) - 1;
  localparam int SCALE_SHIFT = COEF_BITS - 1;

  // magnitude after the 2^15 shift, clamped where the output saturates anyway
  localparam int  T_W         = 2 * SAMPLE_W;
  localparam int  T_CLAMP     = FULL_SCALE * (HALF_SCALE + 2);
  localparam int  Q_W         = SAMPLE_W;
  localparam int  RECIP_SHIFT = 36;
  localparam int  RECIP_W     = 25;
  localparam longint RECIP    = ((64'd1 << RECIP_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 1;

  localparam int TAP_LSB    = 0;
  localparam int COEF_LSB   = TAP_LSB + TAP_FIELD_W;
  localparam int SAMPLE_LSB = COEF_LSB + COEF_BITS;
  localparam int USER_OP    = 0;
  localparam int USER_BANK  = 1;
  localparam int USER_CLIP  = 0;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_FILTER = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ABS,
    ST_SCALE,
    ST_RECIP,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    op_t                         op;
    logic                        bank;
    logic [TAP_IDX_W-1:0]        idx;
    logic [COEF_BITS-1:0]        coef;
    logic signed [X_W-1:0]       x;
    logic                        last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/bfir_ram.sv
`default_nettype none

module bfir_ram #(
  parameter int WIDTH = bfir_pkg::COEF_BITS,
  parameter int DEPTH = bfir_pkg::TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/bfir_queue.sv
`default_nettype none

module bfir_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bfir_pkg::cmd_t    cmd_in,
  input  logic              pop,
  output bfir_pkg::cmd_t    cmd_out,
  output bfir_pkg::q_stat_t stat
);

  import bfir_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign cmd_out    = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

`default_nettype wire

// File: rtl/core/bfir_front.sv
`default_nettype none

module bfir_front #(
  parameter int TAPS = bfir_pkg::TAPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bfir_pkg::IN_DATA_W-1:0] in_tdata,   // tap_index, coef_value, sample
  input  logic [bfir_pkg::IN_USER_W-1:0] in_tuser,   // op, coef_bank
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data,   // bank_select
  input  bfir_pkg::q_stat_t              q_stat,
  output logic                           q_push,
  output bfir_pkg::cmd_t                 q_cmd
);

  import bfir_pkg::*;

  localparam int IDX_W = $clog2(TAPS);

  logic                   bank_select_r;
  logic [IDX_W-1:0]       pos_r;
  logic                   accept;
  op_t                    op;
  logic [TAP_FIELD_W-1:0] tap;
  logic [SAMPLE_W-1:0]    sample;
  logic                   tap_ok;
  logic                   pos_last;

  assign in_tready = !q_stat.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  assign op       = op_t'(in_tuser[USER_OP]);
  assign tap      = in_tdata[TAP_LSB +: TAP_FIELD_W];
  assign sample   = in_tdata[SAMPLE_LSB +: SAMPLE_W];
  assign tap_ok   = (int'(tap) < TAPS);
  assign pos_last = (pos_r == IDX_W'(TAPS - 1));

  // loads past the last tap are dropped here
  assign q_push = accept && ((op == OP_FILTER) || tap_ok);

  always_comb begin
    q_cmd      = '0;
    q_cmd.op   = op;
    q_cmd.coef = in_tdata[COEF_LSB +: COEF_BITS];
    q_cmd.x    = $signed(X_W'({sample, 1'b0}) - X_W'(FULL_SCALE));
    if (op == OP_FILTER) begin
      q_cmd.bank = bank_select_r;
      q_cmd.idx  = TAP_IDX_W'(pos_r);
      q_cmd.last = pos_last;
    end else begin
      q_cmd.bank = in_tuser[USER_BANK];
      q_cmd.idx  = TAP_IDX_W'(tap);
      q_cmd.last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_select_r <= 1'b0;
      pos_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bank_select_r <= cfg_data;
      end
      if (accept && (op == OP_FILTER)) begin
        pos_r <= pos_last ? '0 : pos_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bfir_back.sv
`default_nettype none

module bfir_back #(
  parameter int TAPS = bfir_pkg::TAPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bfir_pkg::q_stat_t               q_stat,
  input  bfir_pkg::cmd_t                  q_cmd,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bfir_pkg::OUT_DATA_W-1:0] out_tdata,  // filtered_sample
  output logic                            out_tlast,
  output logic [bfir_pkg::OUT_USER_W-1:0] out_tuser   // clipped
);

  import bfir_pkg::*;

  localparam int IDX_W  = $clog2(TAPS);
  localparam int CA_W   = $clog2(2 * TAPS);
  localparam int PROD_W = X_W + COEF_BITS;
  localparam int ACC_W  = PROD_W + IDX_W;
  localparam int M_W    = ACC_W + HS_SHIFT;
  localparam int TF_W   = M_W - SCALE_SHIFT;
  localparam int RP_W   = T_W + RECIP_W;

  back_state_t state_r, state_nxt;

  logic                     coef_we, hist_we, out_load;
  logic [CA_W-1:0]          coef_waddr, coef_raddr;
  logic [COEF_BITS-1:0]     coef_rdata;
  logic [IDX_W-1:0]         hist_raddr;
  logic [X_W-1:0]           hist_rdata;

  logic                     bank_r, last_r;
  logic [IDX_W-1:0]         pos_r, k_r;
  logic                     issuing_r, rd_v_r, prod_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     neg_r;
  logic [ACC_W-1:0]         abs_r;
  logic [T_W-1:0]           t_r;
  logic [Q_W-1:0]           qe_r;

  logic                     out_tvalid_r, out_last_r, out_clip_r;
  logic [SAMPLE_W-1:0]      out_data_r;

  logic [M_W-1:0]           m;
  logic [TF_W-1:0]          t_full;
  logic [RP_W-1:0]          rp;
  logic [T_W-1:0]           q_x_fs, rem;
  logic [Q_W-1:0]           q_fix;
  logic                     clip;
  logic [SAMPLE_W-1:0]      y;

  assign coef_waddr = (q_cmd.bank ? CA_W'(TAPS) : CA_W'(0)) + CA_W'(q_cmd.idx[IDX_W-1:0]);
  assign coef_raddr = (bank_r ? CA_W'(TAPS) : CA_W'(0)) + CA_W'(k_r);
  assign hist_raddr = pos_r - k_r;

  bfir_ram #(.WIDTH(COEF_BITS), .DEPTH(2 * TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (q_cmd.coef),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  bfir_ram #(.WIDTH(X_W), .DEPTH(TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (q_cmd.idx[IDX_W-1:0]),
    .wdata (q_cmd.x),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    coef_we   = 1'b0;
    hist_we   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (q_cmd.op == OP_FILTER) begin
            hist_we   = 1'b1;
            state_nxt = ST_MAC;
          end else begin
            coef_we = 1'b1;
          end
        end
      end
      ST_MAC: begin
        if (!issuing_r && !rd_v_r && !prod_v_r) begin
          state_nxt = ST_ABS;
        end
      end
      ST_ABS:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_RECIP;
      ST_RECIP: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // |acc| * 2047 / 2^15, then divide by 4095 via reciprocal and one correction
  assign m      = {abs_r, HS_SHIFT'(0)} - M_W'(abs_r);
  assign t_full = m[M_W-1:SCALE_SHIFT];
  assign rp     = t_r * RP_W'(RECIP);
  assign q_x_fs = {qe_r, FS_SHIFT'(0)} - T_W'(qe_r);
  assign rem    = t_r - q_x_fs;
  assign q_fix  = qe_r + Q_W'(rem >= T_W'(FULL_SCALE));

  always_comb begin
    if (neg_r) begin
      clip = (q_fix > Q_W'(HALF_SCALE));
      y    = clip ? '0 : SAMPLE_W'(HALF_SCALE) - q_fix;
    end else begin
      clip = (q_fix > Q_W'(HALF_SCALE + 1));
      y    = clip ? SAMPLE_W'(FULL_SCALE) : SAMPLE_W'(HALF_SCALE) + q_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issuing_r    <= 1'b0;
      rd_v_r       <= 1'b0;
      prod_v_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_v_r   <= (state_r == ST_MAC) && issuing_r;
      prod_v_r <= rd_v_r;
      if (hist_we) begin
        issuing_r <= 1'b1;
      end else if (issuing_r && (k_r == pos_r)) begin
        issuing_r <= 1'b0;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      bank_r <= q_cmd.bank;
      pos_r  <= q_cmd.idx[IDX_W-1:0];
      last_r <= q_cmd.last;
      k_r    <= '0;
      acc_r  <= '0;
    end else begin
      if (issuing_r && (k_r != pos_r)) begin
        k_r <= k_r + 1'b1;
      end
      if (prod_v_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
    prod_r <= $signed(coef_rdata) * $signed(hist_rdata);
    if (state_r == ST_ABS) begin
      neg_r <= acc_r[ACC_W-1];
      abs_r <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    end
    if (state_r == ST_SCALE) begin
      t_r <= (t_full >= TF_W'(T_CLAMP)) ? T_W'(T_CLAMP) : t_full[T_W-1:0];
    end
    if (state_r == ST_RECIP) begin
      qe_r <= rp[RECIP_SHIFT +: Q_W];
    end
    if (out_load) begin
      out_data_r <= y;
      out_last_r <= last_r;
      out_clip_r <= clip;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = OUT_USER_W'(out_clip_r);

endmodule

`default_nettype wire

// File: rtl/core/block_fir_filter_two_banks_top.sv
// Operation: a sample at block position p is filtered in the single shared multiply-accumulate
//   loop, one tap per cycle; the back end takes no new command until its result is loaded out.
// A 2-entry command queue lets the input side accept while the filter loop runs.
// Reset (rst_n, synchronous): clears block position, bank_select and all handshake state;
//   coefficient and history memories are not cleared, coefficients are undefined until loaded.
`default_nettype none

module block_fir_filter_two_banks_top #(
  parameter int TAPS = bfir_pkg::TAPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bfir_pkg::IN_DATA_W-1:0]  in_tdata,   // tap_index, coef_value, sample
  input  logic [bfir_pkg::IN_USER_W-1:0]  in_tuser,   // op, coef_bank
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bfir_pkg::OUT_DATA_W-1:0] out_tdata,  // filtered_sample
  output logic                            out_tlast,
  output logic [bfir_pkg::OUT_USER_W-1:0] out_tuser,  // clipped
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data    // bank_select
);

  import bfir_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd, pop_cmd;
  logic    q_push, q_pop;

  bfir_front #(.TAPS(TAPS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  bfir_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (push_cmd),
    .pop     (q_pop),
    .cmd_out (pop_cmd),
    .stat    (q_stat)
  );

  bfir_back #(.TAPS(TAPS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> !q_stat.empty)
    else $error("queue empty after push");

endmodule

`default_nettype wire

// File: tb/block_fir_filter_two_banks_checker.sv
`timescale 1ns / 1ps

module block_fir_filter_two_banks_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bfir_pkg::IN_DATA_W-1:0]  in_tdata,   // tap_index, coef_value, sample
  input  logic [bfir_pkg::IN_USER_W-1:0]  in_tuser,   // op, coef_bank
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bfir_pkg::OUT_DATA_W-1:0] out_tdata,  // filtered_sample
  input  logic                            out_tlast,
  input  logic [bfir_pkg::OUT_USER_W-1:0] out_tuser,  // clipped
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic                            cfg_data,   // bank_select
  output int                              mismatches,
  output int                              outstanding
);

  localparam int NUM_TAPS = bfir_pkg::TAPS_DEF;

  typedef struct packed {
    logic [bfir_pkg::SAMPLE_W-1:0] level;
    logic                          last;
    logic                          clip;
  } fir_result_t;

  int          coef_mem [2][NUM_TAPS];
  int          sample_hist [NUM_TAPS];
  int          block_pos;
  logic        bank_sel;
  fir_result_t expected_out [$];

  function automatic fir_result_t filter_step(input logic [bfir_pkg::SAMPLE_W-1:0] raw);
    fir_result_t r;
    longint      acc;
    longint      y;
    int          k;
    acc = 0;
    sample_hist[block_pos] = 2 * int'(raw) - bfir_pkg::FULL_SCALE;
    for (k = 0; k <= block_pos; k++)
      acc += longint'(coef_mem[bank_sel][k]) * longint'(sample_hist[block_pos - k]);
    y = (acc * bfir_pkg::HALF_SCALE)
        / (longint'(bfir_pkg::FULL_SCALE) * (longint'(1) << bfir_pkg::SCALE_SHIFT))
        + bfir_pkg::HALF_SCALE;
    r.clip = 1'b0;
    if (y < 0) begin
      y = 0;
      r.clip = 1'b1;
    end else if (y > bfir_pkg::FULL_SCALE) begin
      y = bfir_pkg::FULL_SCALE;
      r.clip = 1'b1;
    end
    r.level = y[bfir_pkg::SAMPLE_W-1:0];
    r.last  = (block_pos == NUM_TAPS - 1);
    block_pos = (block_pos == NUM_TAPS - 1) ? 0 : block_pos + 1;
    return r;
  endfunction

  task automatic report(input string what, input fir_result_t want, input fir_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected level %0d last %0b clip %0b, got level %0d last %0b clip %0b",
               $time, what, want.level, want.last, want.clip, got.level, got.last, got.clip);
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    fir_result_t got;
    fir_result_t want;
    if (!rst_n) begin
      bank_sel  = 1'b0;
      block_pos = 0;
      expected_out.delete();
      foreach (coef_mem[b, t]) coef_mem[b][t] = 0;
      foreach (sample_hist[t]) sample_hist[t] = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        bank_sel = cfg_data;
      if (in_tvalid && in_tready) begin
        if (bfir_pkg::op_t'(in_tuser[bfir_pkg::USER_OP]) == bfir_pkg::OP_LOAD)
          coef_mem[in_tuser[bfir_pkg::USER_BANK]]
                  [in_tdata[bfir_pkg::TAP_LSB +: bfir_pkg::TAP_FIELD_W]] =
            int'($signed(in_tdata[bfir_pkg::COEF_LSB +: bfir_pkg::COEF_BITS]));
        else
          expected_out.push_back(
            filter_step(in_tdata[bfir_pkg::SAMPLE_LSB +: bfir_pkg::SAMPLE_W]));
      end
      if (out_tvalid && out_tready) begin
        got.level = out_tdata[bfir_pkg::SAMPLE_W-1:0];
        got.last  = out_tlast;
        got.clip  = out_tuser[bfir_pkg::USER_CLIP];
        if (expected_out.size() == 0) begin
          want = '0;
          report("unexpected transaction", want, got);
        end else begin
          want = expected_out.pop_front();
          if (got != want)
            report("output mismatch", want, got);
        end
      end
    end
    outstanding = expected_out.size();
  end

endmodule

// File: tb/block_fir_filter_two_banks_top_test.sv
`timescale 1ns / 1ps

module block_fir_filter_two_banks_top_test;

  localparam int NUM_TAPS    = bfir_pkg::TAPS_DEF;
  localparam int STALL_LIMIT = 4000;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [bfir_pkg::IN_DATA_W-1:0]  in_tdata;   // tap_index, coef_value, sample
  logic [bfir_pkg::IN_USER_W-1:0]  in_tuser;   // op, coef_bank
  logic                            out_tvalid;
  logic                            out_tready;
  logic [bfir_pkg::OUT_DATA_W-1:0] out_tdata;  // filtered_sample
  logic                            out_tlast;
  logic [bfir_pkg::OUT_USER_W-1:0] out_tuser;  // clipped
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic                            cfg_data;   // bank_select

  int mismatches;
  int outstanding;
  int stall_cycles;
  bit steady;

  block_fir_filter_two_banks_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  block_fir_filter_two_banks_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL block_fir_filter_two_banks_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_item(input bfir_pkg::op_t op, input logic bank,
                           input logic [5:0] tap, input logic [15:0] coef,
                           input logic [11:0] sample);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) repeat (gap) @(negedge clk);
    in_tdata = '0;
    in_tdata[bfir_pkg::TAP_LSB +: bfir_pkg::TAP_FIELD_W]  = tap;
    in_tdata[bfir_pkg::COEF_LSB +: bfir_pkg::COEF_BITS]   = coef;
    in_tdata[bfir_pkg::SAMPLE_LSB +: bfir_pkg::SAMPLE_W]  = sample;
    in_tuser = '0;
    in_tuser[bfir_pkg::USER_OP]   = op;
    in_tuser[bfir_pkg::USER_BANK] = bank;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic load_coef(input logic bank, input logic [5:0] tap, input logic [15:0] value);
    send_item(bfir_pkg::OP_LOAD, bank, tap, value, 12'($urandom));
  endtask

  task automatic filter(input logic [11:0] sample);
    send_item(bfir_pkg::OP_FILTER, 1'($urandom), 6'($urandom), 16'($urandom), sample);
  endtask

  // bank_select only changes while the datapath is drained
  task automatic write_bank(input logic value);
    wait (outstanding == 0);
    repeat (100) @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_coef(input int mode);
    case (mode)
      0:       return 16'($urandom_range(0, 2048)) - 16'd1024;
      1:       return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 12'd0;
      1:       return 12'hFFF;
      2:       return 12'($urandom_range(2000, 2095));
      default: return 12'($urandom);
    endcase
  endfunction

  initial begin
    int mode;
    steady    = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_bank(1'b0);
    // every coefficient defined before the first sample
    for (int b = 0; b < 2; b++)
      for (int t = 0; t < NUM_TAPS; t++)
        load_coef(b[0], 6'(t), pick_coef(0));

    load_coef(1'b0, 6'd0, 16'h7FFF);
    load_coef(1'b0, 6'd1, 16'h7FFF);
    filter(12'hFFF);
    filter(12'hFFF);
    filter(12'h000);
    filter(12'h000);
    load_coef(1'b0, 6'd0, 16'h8000);
    filter(12'd2047);
    filter(12'd2048);
    filter(12'hFFF);
    load_coef(1'b1, 6'd0, 16'h8000);
    load_coef(1'b1, 6'd63, 16'h7FFF);
    load_coef(1'b1, 6'd42, 16'h5555);
    load_coef(1'b0, 6'd21, 16'hAAAA);
    write_bank(1'b1);
    filter(12'hFFF);
    filter(12'h000);
    filter(12'hAAA);
    filter(12'h555);
    write_bank(1'b0);
    filter(12'h001);
    filter(12'h800);

    for (int phase = 0; phase < 8; phase++) begin
      mode   = phase % 3;
      steady = (phase == 2);
      write_bank(phase < 4 ? phase[0] : 1'($urandom));
      repeat ($urandom_range(4, 16))
        load_coef(1'($urandom), 6'($urandom), pick_coef(mode));
      for (int i = 0; i < 75; i++) begin
        if (phase == 3 && i == 50) wait (outstanding == 0);
        if ($urandom_range(0, 9) == 0)
          load_coef(1'($urandom), 6'($urandom), pick_coef(mode));
        else
          filter(pick_sample());
      end
    end
    steady = 1'b0;

    wait (outstanding == 0);
    repeat (100) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS block_fir_filter_two_banks_top");
    end else begin
      $display("FAIL block_fir_filter_two_banks_top");
    end
    $finish;
  end

endmodule
